// ===== src/ucu8_pkg.sv =====
// shared types, codes and sizes for the unicode to utf-8 transcoder
package ucu8_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [2:0] ENC_LATIN1 = 3'd0;
   localparam logic [2:0] ENC_UTF16LE = 3'd1;
   localparam logic [2:0] ENC_UTF16BE = 3'd2;
   localparam logic [2:0] ENC_UTF32LE = 3'd3;
   localparam logic [2:0] ENC_UTF32BE = 3'd4;

   localparam logic [1:0] STATUS_DATA = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   localparam logic [31:0] SURR_HIGH_FIRST = 32'h0000_D800;
   localparam logic [31:0] SURR_HIGH_LAST = 32'h0000_DBFF;
   localparam logic [31:0] SURR_LOW_FIRST = 32'h0000_DC00;
   localparam logic [31:0] SURR_LOW_LAST = 32'h0000_DFFF;
   localparam logic [31:0] CODE_POINT_MAX = 32'h0010_FFFF;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] status;
      logic       last_in_run;
   } rsp_word_type;

   // one classified word: up to four data bytes then an optional status
   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  data_count;
      logic [1:0]  tail_status;
   } job_type;

endpackage

// ===== src/ucu8_front.sv =====
// front end: assembles code units, joins surrogates, classifies each word
module ucu8_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ucu8_pkg::req_word_type req_data,
   input  logic                  csr_write_enable,
   input  logic [2:0]            csr_write_data,
   input  logic                  queue_full,
   output logic                  push,
   output ucu8_pkg::job_type     push_job
);
   import ucu8_pkg::*;

   logic [2:0]  enc_ff, enc_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  held_ff, held_in;
   logic [9:0]  phb_ff, phb_in;
   logic        phv_ff, phv_in;
   logic        err_ff, err_in;

   logic        accept;
   logic        unicode, little, wide, complete;
   logic [31:0] acc_shift, unit;
   logic        emit, invalid;
   logic [20:0] cp;
   logic        eos;
   logic [7:0]  b;

   assign req_stall = queue_full;
   assign accept = req_valid && !queue_full;
   assign eos = req_data.end_of_stream;
   assign b = req_data.in_byte;

   always_comb begin
      unicode = 1'b1;
      little = 1'b0;
      wide = 1'b0;
      unique case (enc_ff)
         ENC_UTF16LE: little = 1'b1;
         ENC_UTF16BE: little = 1'b0;
         ENC_UTF32LE: begin
            little = 1'b1;
            wide = 1'b1;
         end
         ENC_UTF32BE: wide = 1'b1;
         default: unicode = 1'b0;
      endcase
   end

   assign acc_shift = little ? {b, acc_ff[31:8]} : {acc_ff[23:0], b};
   assign complete = wide ? (held_ff == 2'd3) : (held_ff != 2'd0);
   assign unit = wide ? acc_shift : (little ? {16'd0, acc_shift[31:16]}
                                            : {16'd0, acc_shift[15:0]});

   function automatic logic [2:0] utf8_length(input logic [20:0] c);
      if (c < 21'h80) return 3'd1;
      else if (c < 21'h800) return 3'd2;
      else if (c < 21'h10000) return 3'd3;
      else return 3'd4;
   endfunction

   always_comb begin
      enc_in = csr_write_enable ? csr_write_data : enc_ff;
      acc_in = acc_ff;
      held_in = held_ff;
      phb_in = phb_ff;
      phv_in = phv_ff;
      err_in = err_ff;
      push = 1'b0;
      push_job = '0;
      emit = 1'b0;
      invalid = 1'b0;
      cp = '0;
      if (accept) begin
         if (err_ff) begin
            if (eos) begin
               acc_in = '0;
               held_in = '0;
               phb_in = '0;
               phv_in = 1'b0;
               err_in = 1'b0;
            end
         end else begin
            if (unicode) begin
               if (complete) begin
                  held_in = '0;
                  acc_in = '0;
                  if (wide) begin
                     if (unit > CODE_POINT_MAX ||
                         (unit >= SURR_HIGH_FIRST && unit <= SURR_LOW_LAST)) begin
                        invalid = 1'b1;
                     end else begin
                        emit = 1'b1;
                        cp = unit[20:0];
                     end
                  end else if (phv_ff) begin
                     if (unit >= SURR_LOW_FIRST && unit <= SURR_LOW_LAST) begin
                        emit = 1'b1;
                        cp = 21'h10000 + {1'b0, phb_ff, unit[9:0]};
                        phv_in = 1'b0;
                        phb_in = '0;
                     end else begin
                        invalid = 1'b1;
                     end
                  end else if (unit >= SURR_HIGH_FIRST && unit <= SURR_HIGH_LAST) begin
                     phb_in = unit[9:0];
                     phv_in = 1'b1;
                  end else if (unit >= SURR_LOW_FIRST && unit <= SURR_LOW_LAST) begin
                     invalid = 1'b1;
                  end else begin
                     emit = 1'b1;
                     cp = unit[20:0];
                  end
               end else begin
                  held_in = held_ff + 2'd1;
                  acc_in = acc_shift;
               end
            end else begin
               emit = 1'b1;
               cp = {13'd0, b};
            end

            if (invalid) begin
               push = 1'b1;
               push_job.tail_status = STATUS_INVALID;
               acc_in = '0;
               held_in = '0;
               phb_in = '0;
               phv_in = 1'b0;
               err_in = !eos;
            end else begin
               push_job.code_point = cp;
               push_job.data_count = emit ? utf8_length(cp) : 3'd0;
               push_job.tail_status = STATUS_DATA;
               if (eos) begin
                  if (held_in != 2'd0 || phv_in) begin
                     push_job.tail_status = STATUS_TRUNCATED;
                  end
                  acc_in = '0;
                  held_in = '0;
                  phb_in = '0;
                  phv_in = 1'b0;
                  err_in = 1'b0;
               end
               push = emit || (push_job.tail_status != STATUS_DATA);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_ff <= ENC_LATIN1;
         acc_ff <= '0;
         held_ff <= '0;
         phb_ff <= '0;
         phv_ff <= 1'b0;
         err_ff <= 1'b0;
      end else begin
         enc_ff <= enc_in;
         acc_ff <= acc_in;
         held_ff <= held_in;
         phb_ff <= phb_in;
         phv_ff <= phv_in;
         err_ff <= err_in;
      end
   end

endmodule

// ===== src/ucu8_queue.sv =====
// small job queue between the front end and the byte emitter
module ucu8_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ucu8_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output ucu8_pkg::job_type head_job
);
   import ucu8_pkg::*;

   job_type                    entries_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign full = (count_ff == QueueCountWidth'(QueueDepth));
   assign not_empty = (count_ff != '0);
   assign head_job = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? QueuePtrWidth'((32'(wr_ptr_ff) + 1) % QueueDepth) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QueuePtrWidth'((32'(rd_ptr_ff) + 1) % QueueDepth) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + QueueCountWidth'(1);
      else if (do_pop && !do_push) count_in = count_ff - QueueCountWidth'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/ucu8_back.sv =====
// back end: expands each job into utf-8 bytes and status words
module ucu8_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  ucu8_pkg::job_type     job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ucu8_pkg::rsp_word_type rsp_data
);
   import ucu8_pkg::*;

   logic [2:0]   index_ff, index_in;
   logic         valid_ff, valid_in;
   rsp_word_type data_ff, data_in;
   logic         load;
   logic [2:0]   total;
   logic         last;
   rsp_word_type word;

   function automatic logic [7:0] utf8_byte(input logic [20:0] c, input logic [2:0] n,
                                            input logic [2:0] k);
      logic [7:0] r;
      r = 8'd0;
      unique case (n)
         3'd1: r = {1'b0, c[6:0]};
         3'd2: r = (k == 3'd0) ? {3'b110, c[10:6]} : {2'b10, c[5:0]};
         3'd3: begin
            case (k)
               3'd0: r = {4'b1110, c[15:12]};
               3'd1: r = {2'b10, c[11:6]};
               default: r = {2'b10, c[5:0]};
            endcase
         end
         3'd4: begin
            case (k)
               3'd0: r = {5'b11110, c[20:18]};
               3'd1: r = {2'b10, c[17:12]};
               3'd2: r = {2'b10, c[11:6]};
               default: r = {2'b10, c[5:0]};
            endcase
         end
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   assign total = job.data_count + {2'd0, (job.tail_status != STATUS_DATA)};
   assign last = ((index_ff + 3'd1) == total);
   assign load = job_valid && (!valid_ff || !rsp_stall);
   assign pop = load && last;

   always_comb begin
      word.last_in_run = last;
      if (index_ff < job.data_count) begin
         word.out_byte = utf8_byte(job.code_point, job.data_count, index_ff);
         word.status = STATUS_DATA;
      end else begin
         word.out_byte = 8'd0;
         word.status = job.tail_status;
      end
   end

   always_comb begin
      index_in = index_ff;
      data_in = data_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         data_in = word;
         index_in = last ? 3'd0 : index_ff + 3'd1;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== src/unicode_to_utf8_transcoder.sv =====
// top level: latin-1 / utf-16 / utf-32 byte stream to utf-8 transcoder
// an accepted input word is queued, then its first result word is registered
// throughput: one input word per cycle while the four-entry job queue has room
// output: one result word per cycle from the emitter's register unless stalled
// a word that yields n results holds the emitter until all n have been sent
// reset clears the stream state, the queue and sets source encoding to latin-1
module unicode_to_utf8_transcoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ucu8_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ucu8_pkg::rsp_word_type rsp_data,
   input  logic                   csr_write_enable,
   input  logic [2:0]             csr_write_data
);
   import ucu8_pkg::*;

   logic    push, full, pop, not_empty;
   job_type push_job, head_job;

   ucu8_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (full),
      .push             (push),
      .push_job         (push_job)
   );

   ucu8_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_job  (head_job)
   );

   ucu8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (not_empty),
      .job       (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/utf8_result_checker.sv =====
`timescale 1ns / 100ps
// checker: predicts utf-8 result words from accepted input words and compares them
module utf8_result_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  ucu8_pkg::req_word_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ucu8_pkg::rsp_word_type rsp_data,
   input  logic                   csr_write_enable,
   input  logic [2:0]             csr_write_data,
   output int                     pending_count,
   output int                     live_words,
   output int                     mismatch_count
);
   import ucu8_pkg::*;

   localparam int MaxPrinted = 40;

   logic [2:0]   encoding;
   logic [31:0]  unit_acc;
   logic [1:0]   held_bytes;
   logic [9:0]   high_half;
   logic         high_waiting;
   logic         stream_failed;

   rsp_word_type expected_utf8[$];
   rsp_word_type step_words[$];

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MaxPrinted) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   function automatic void clear_stream();
      unit_acc = '0;
      held_bytes = '0;
      high_half = '0;
      high_waiting = 1'b0;
      stream_failed = 1'b0;
   endfunction

   function automatic void put_word(logic [7:0] value, logic [1:0] status);
      rsp_word_type w;
      w.out_byte = value;
      w.status = status;
      w.last_in_run = 1'b0;
      step_words.insert(step_words.size(), w);
   endfunction

   function automatic void put_utf8(logic [31:0] cp);
      if (cp < 32'h80) begin
         put_word(cp[7:0], STATUS_DATA);
      end else if (cp < 32'h800) begin
         put_word({3'b110, cp[10:6]}, STATUS_DATA);
         put_word({2'b10, cp[5:0]}, STATUS_DATA);
      end else if (cp < 32'h10000) begin
         put_word({4'b1110, cp[15:12]}, STATUS_DATA);
         put_word({2'b10, cp[11:6]}, STATUS_DATA);
         put_word({2'b10, cp[5:0]}, STATUS_DATA);
      end else begin
         put_word({5'b11110, cp[20:18]}, STATUS_DATA);
         put_word({2'b10, cp[17:12]}, STATUS_DATA);
         put_word({2'b10, cp[11:6]}, STATUS_DATA);
         put_word({2'b10, cp[5:0]}, STATUS_DATA);
      end
   endfunction

   task automatic transcode_word(input req_word_type w);
      logic [31:0] unit;
      logic [31:0] cp;
      logic        little;
      logic        wide;
      logic        invalid;
      int          unit_size;
      step_words.delete();
      invalid = 1'b0;
      live_words++;
      if (stream_failed) begin
         if (w.end_of_stream) clear_stream();
         return;
      end
      if (encoding >= ENC_UTF16LE && encoding <= ENC_UTF32BE) begin
         little = (encoding == ENC_UTF16LE) || (encoding == ENC_UTF32LE);
         wide = (encoding >= ENC_UTF32LE);
         unit_size = wide ? 4 : 2;
         unit_acc = little ? {w.in_byte, unit_acc[31:8]} : {unit_acc[23:0], w.in_byte};
         if (int'(held_bytes) + 1 >= unit_size) begin
            held_bytes = '0;
            if (wide) unit = unit_acc;
            else if (little) unit = {16'h0, unit_acc[31:16]};
            else unit = {16'h0, unit_acc[15:0]};
            unit_acc = '0;
            if (wide) begin
               if (unit > CODE_POINT_MAX || (unit >= SURR_HIGH_FIRST && unit <= SURR_LOW_LAST))
                  invalid = 1'b1;
               else
                  put_utf8(unit);
            end else if (high_waiting) begin
               if (unit >= SURR_LOW_FIRST && unit <= SURR_LOW_LAST) begin
                  cp = 32'h10000 + {12'h0, high_half, 10'h0} + (unit - SURR_LOW_FIRST);
                  high_waiting = 1'b0;
                  high_half = '0;
                  put_utf8(cp);
               end else begin
                  invalid = 1'b1;
               end
            end else if (unit >= SURR_HIGH_FIRST && unit <= SURR_HIGH_LAST) begin
               high_half = unit[9:0];
               high_waiting = 1'b1;
            end else if (unit >= SURR_LOW_FIRST && unit <= SURR_LOW_LAST) begin
               invalid = 1'b1;
            end else begin
               put_utf8(unit);
            end
         end else begin
            held_bytes = held_bytes + 2'd1;
         end
      end else begin
         put_utf8({24'h0, w.in_byte});
      end
      if (invalid) begin
         step_words.delete();
         put_word(8'h00, STATUS_INVALID);
         clear_stream();
         stream_failed = !w.end_of_stream;
      end else if (w.end_of_stream) begin
         if (held_bytes != 0 || high_waiting) put_word(8'h00, STATUS_TRUNCATED);
         clear_stream();
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].last_in_run = 1'b1;
      foreach (step_words[i]) expected_utf8.insert(expected_utf8.size(), step_words[i]);
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         encoding = ENC_LATIN1;
         clear_stream();
         expected_utf8.delete();
         pending_count <= 0;
      end else begin
         if (csr_write_enable) encoding = csr_write_data;
         if (req_valid && !req_stall) transcode_word(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_utf8.size() == 0) begin
               report_mismatch($sformatf("word %0h/%0d/%0d with none expected",
                  rsp_data.out_byte, rsp_data.status, rsp_data.last_in_run));
            end else begin
               want = expected_utf8.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %0h, expected %0h",
                     rsp_data.out_byte, want.out_byte));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                     rsp_data.status, want.status));
               if (rsp_data.last_in_run !== want.last_in_run)
                  report_mismatch($sformatf("last_in_run %0d, expected %0d",
                     rsp_data.last_in_run, want.last_in_run));
            end
         end
         pending_count <= expected_utf8.size();
      end
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// testbench top: clock, reset, stimulus and pacing for the utf-8 transcoder
module testbench;
   import ucu8_pkg::*;

   localparam logic [2:0] ENC_UNKNOWN_LAST = 3'd7;
   localparam int RandomWords = 500;
   localparam int DrainCycles = 12;
   localparam int LongHoldCycles = 300;

   typedef enum {PACE_FREE, PACE_LIGHT, PACE_HEAVY, PACE_TOGGLE} pace_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b1;
   rsp_word_type rsp_data;
   logic         csr_write_enable = 1'b0;
   logic [2:0]   csr_write_data = '0;

   int           pending_count;
   int           live_words;
   int           mismatch_count;

   logic         hold_armed = 1'b0;
   logic [2:0]   current_encoding = ENC_LATIN1;
   int           burst_left = 0;
   req_word_type stream_bytes[$];

   unicode_to_utf8_transcoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   utf8_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pending_count    (pending_count),
      .live_words       (live_words),
      .mismatch_count   (mismatch_count)
   );

   always #10 clock = ~clock;

   task automatic send_word(input req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   task automatic send_stream();
      foreach (stream_bytes[i]) send_word(stream_bytes[i]);
      stream_bytes.delete();
   endtask

   task automatic set_encoding(input logic [2:0] enc);
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DrainCycles) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= enc;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      current_encoding = enc;
   endtask

   function automatic void add_byte(logic [7:0] value, logic eos);
      req_word_type w;
      w.in_byte = value;
      w.end_of_stream = eos;
      stream_bytes.insert(stream_bytes.size(), w);
   endfunction

   function automatic void mark_end();
      if (stream_bytes.size() > 0) stream_bytes[stream_bytes.size() - 1].end_of_stream = 1'b1;
   endfunction

   function automatic void add_unit16(logic [15:0] u);
      if (current_encoding == ENC_UTF16LE) begin
         add_byte(u[7:0], 1'b0);
         add_byte(u[15:8], 1'b0);
      end else begin
         add_byte(u[15:8], 1'b0);
         add_byte(u[7:0], 1'b0);
      end
   endfunction

   function automatic void add_unit32(logic [31:0] u);
      if (current_encoding == ENC_UTF32LE) begin
         for (int i = 0; i < 4; i++) add_byte(u[8*i +: 8], 1'b0);
      end else begin
         for (int i = 3; i >= 0; i--) add_byte(u[8*i +: 8], 1'b0);
      end
   endfunction

   function automatic void add_code_point(logic [31:0] cp);
      logic [31:0] v;
      if (current_encoding >= ENC_UTF32LE) begin
         add_unit32(cp);
      end else if (cp < 32'h10000) begin
         add_unit16(cp[15:0]);
      end else begin
         v = cp - 32'h10000;
         add_unit16(SURR_HIGH_FIRST[15:0] + {6'h0, v[19:10]});
         add_unit16(SURR_LOW_FIRST[15:0] + {6'h0, v[9:0]});
      end
   endfunction

   function automatic logic [31:0] pick_code_point();
      logic [31:0] cp;
      case ($urandom_range(0, 3))
         0: cp = $urandom_range(0, 32'h7F);
         1: cp = $urandom_range(32'h80, 32'h7FF);
         2: begin
            cp = $urandom_range(32'h800, 32'hF7FF);
            if (cp >= SURR_HIGH_FIRST) cp = cp + 32'h800;
         end
         default: cp = $urandom_range(32'h10000, CODE_POINT_MAX);
      endcase
      return cp;
   endfunction

   task automatic build_phase(input int target);
      int  pick;
      logic wide;
      wide = (current_encoding == ENC_UTF32LE) || (current_encoding == ENC_UTF32BE);
      while (stream_bytes.size() < target) begin
         pick = $urandom_range(0, 99);
         if (current_encoding < ENC_UTF16LE || current_encoding > ENC_UTF32BE) begin
            add_byte(8'($urandom_range(0, 255)), 1'b0);
         end else if (pick < 72) begin
            add_code_point(pick_code_point());
         end else if (pick < 80) begin
            if (wide) add_unit32($urandom_range(SURR_HIGH_FIRST, SURR_LOW_LAST));
            else add_unit16(16'($urandom_range(SURR_HIGH_FIRST, SURR_HIGH_LAST)));
         end else if (pick < 86) begin
            if (wide) add_unit32($urandom_range(CODE_POINT_MAX + 1, 32'hFFFF_FFFF));
            else add_unit16(16'($urandom_range(SURR_LOW_FIRST, SURR_LOW_LAST)));
         end else begin
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
         end
         if ($urandom_range(0, 99) < 8) mark_end();
      end
   endtask

   // receiver pacing, with one long hold-off on request
   initial begin : rsp_pacing
      pace_type style;
      int       run;
      @(posedge clock);
      forever begin
         if (hold_armed) begin
            hold_armed = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LongHoldCycles) @(posedge clock);
         end else begin
            style = pace_type'($urandom_range(0, 3));
            run = $urandom_range(1, 40);
            repeat (run) begin
               case (style)
                  PACE_FREE:  rsp_stall <= 1'b0;
                  PACE_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                  PACE_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default:    rsp_stall <= ~rsp_stall;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int         base_words;
      int         phase;
      int         pick;
      logic [2:0] enc;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      set_encoding(ENC_LATIN1);
      add_byte(8'h00, 1'b0);
      add_byte(8'h7F, 1'b0);
      add_byte(8'hFF, 1'b1);
      send_stream();

      // surrogate pair, lone low half, dropped bytes after the error
      set_encoding(ENC_UTF16LE);
      add_code_point(32'h1F600);
      add_unit16(SURR_LOW_FIRST[15:0]);
      add_byte(8'h55, 1'b0);
      add_byte(8'h66, 1'b1);
      send_stream();

      // dangling high half and partial unit at end of stream
      set_encoding(ENC_UTF16BE);
      add_unit16(16'hFFFF);
      add_unit16(SURR_HIGH_FIRST[15:0]);
      add_byte(8'h12, 1'b1);
      send_stream();

      set_encoding(ENC_UTF32BE);
      add_unit32(CODE_POINT_MAX);
      add_unit32(CODE_POINT_MAX + 1);
      mark_end();
      send_stream();

      set_encoding(ENC_UTF32LE);
      add_unit32(SURR_LOW_LAST);
      mark_end();
      send_stream();

      set_encoding(ENC_UNKNOWN_LAST);
      add_byte(8'hC3, 1'b1);
      send_stream();

      base_words = live_words;
      phase = 0;
      while (live_words - base_words < RandomWords) begin
         pick = $urandom_range(0, 11);
         if (pick < 8) enc = ENC_UTF16LE + {1'b0, pick[1:0]};
         else if (pick < 10) enc = ENC_LATIN1;
         else enc = 3'($urandom_range(ENC_UTF32BE + 1, ENC_UNKNOWN_LAST));
         set_encoding(enc);
         build_phase($urandom_range(20, 60));
         if (phase == 1 || phase == 6) hold_armed = 1'b1;
         send_stream();
         phase++;
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** unicode_to_utf8_transcoder: PASSED **");
      end else begin
         $display("** unicode_to_utf8_transcoder: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("** unicode_to_utf8_transcoder: FAILED **");
      $finish;
   end

endmodule
